// ----- design/orsp_pkg.sv -----
`default_nettype none
package orsp_pkg;

    localparam int CODE_SHOW_MAX_DEF = 20;

    // queue between front and back, and result queue
    localparam int Q_DEPTH = 2;
    localparam int QA_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    localparam logic [3:0] EV_START  = 4'd0;
    localparam logic [3:0] EV_NUMBER = 4'd1;
    localparam logic [3:0] EV_CODE   = 4'd2;
    localparam logic [3:0] EV_CHAR   = 4'd3;
    localparam logic [3:0] EV_STREND = 4'd4;
    localparam logic [3:0] EV_PATCH  = 4'd5;
    localparam logic [3:0] EV_TARGET = 4'd6;
    localparam logic [3:0] EV_DONE   = 4'd7;
    localparam logic [3:0] EV_ERROR  = 4'd8;

    localparam logic [3:0] K_CODE   = 4'd0;
    localparam logic [3:0] K_BSS    = 4'd1;
    localparam logic [3:0] K_INIT   = 4'd2;
    localparam logic [3:0] K_BYTE   = 4'd3;
    localparam logic [3:0] K_SHORT  = 4'd4;
    localparam logic [3:0] K_WORD   = 4'd5;
    localparam logic [3:0] K_MODULE = 4'd6;
    localparam logic [3:0] K_GLOBAL = 4'd7;
    localparam logic [3:0] K_LABEL  = 4'd8;
    localparam logic [3:0] K_DATA   = 4'd9;
    localparam logic [3:0] K_COMMON = 4'd10;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_TAG    = 2'd1;
    localparam logic [1:0] ERR_TARGET = 2'd2;
    localparam logic [1:0] ERR_END    = 2'd3;

    localparam logic [1:0] TK_MODULE = 2'd3;

    localparam logic [7:0] PATCH_BASE  = 8'h12;
    localparam logic [7:0] TARGET_BASE = 8'h0f;

    // one classified stream byte
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       tag_ok;
        logic [3:0] tag_kind;
        logic       is_ptag;
        logic       is_tgt;
        logic       is_mtgt;
    } t_item;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [3:0]  record_kind;
        logic [31:0] value;
        logic [3:0]  patch_index;
        logic [1:0]  target_kind;
        logic [1:0]  error_code;
        logic [31:0] record_pc;
        logic        record_done;
    } t_result;

endpackage
`default_nettype wire

// ----- design/orsp_front.sv -----
`default_nettype none
module orsp_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    output logic                 o_full,
    input  wire  [7:0]           i_data_byte,
    input  wire                  i_stream_end,
    output logic                 o_q_valid,
    output orsp_pkg::t_item      o_q_item,
    input  wire                  i_q_pop
);

    orsp_pkg::t_item                 w_item;
    orsp_pkg::t_item                 r_mem [orsp_pkg::Q_DEPTH];
    logic [orsp_pkg::QA_W-1:0]       r_wr, n_wr, r_rd, n_rd;
    logic [orsp_pkg::QC_W-1:0]       r_cnt, n_cnt;
    logic                            w_push, w_pop;

    // classify the byte as tag, patch tag or target tag
    always_comb begin
        w_item          = '0;
        w_item.data     = i_data_byte;
        w_item.is_end   = i_stream_end;
        w_item.tag_ok   = 1'b1;
        case (i_data_byte)
            8'h01: w_item.tag_kind = orsp_pkg::K_CODE;
            8'h02: w_item.tag_kind = orsp_pkg::K_BSS;
            8'h03: w_item.tag_kind = orsp_pkg::K_INIT;
            8'h09: w_item.tag_kind = orsp_pkg::K_BYTE;
            8'h0a: w_item.tag_kind = orsp_pkg::K_SHORT;
            8'h0c: w_item.tag_kind = orsp_pkg::K_WORD;
            8'h20: w_item.tag_kind = orsp_pkg::K_MODULE;
            8'h22: w_item.tag_kind = orsp_pkg::K_GLOBAL;
            8'h23: w_item.tag_kind = orsp_pkg::K_LABEL;
            8'h24: w_item.tag_kind = orsp_pkg::K_DATA;
            8'h25: w_item.tag_kind = orsp_pkg::K_COMMON;
            default: begin
                w_item.tag_ok   = 1'b0;
                w_item.tag_kind = orsp_pkg::K_CODE;
            end
        endcase
        w_item.is_ptag  = i_data_byte inside {[8'h13:8'h1f]};
        w_item.is_tgt   = i_data_byte inside {[8'h0f:8'h11]};
        w_item.is_mtgt  = (i_data_byte == 8'h12);
    end

    assign o_full    = (r_cnt == orsp_pkg::QC_W'(orsp_pkg::Q_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rd];
    assign w_push    = i_push && !o_full;
    assign w_pop     = i_q_pop && o_q_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == orsp_pkg::QA_W'(orsp_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == orsp_pkg::QA_W'(orsp_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

endmodule
`default_nettype wire

// ----- design/orsp_back.sv -----
`default_nettype none
module orsp_back #(
    parameter int CODE_SHOW_MAX = orsp_pkg::CODE_SHOW_MAX_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_q_valid,
    input  wire orsp_pkg::t_item i_q_item,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  wire                  i_pop,
    output orsp_pkg::t_result    o_res
);

    localparam logic [2:0] PH_TAG       = 3'd0;
    localparam logic [2:0] PH_NUM_FIRST = 3'd1;
    localparam logic [2:0] PH_NUM_CONT  = 3'd2;
    localparam logic [2:0] PH_CODE      = 3'd3;
    localparam logic [2:0] PH_STRING    = 3'd4;
    localparam logic [2:0] PH_PATCH     = 3'd5;
    localparam logic [2:0] PH_DONE      = 3'd6;
    localparam logic [2:0] PH_ERR       = 3'd7;

    localparam logic [7:0] SHOW_MAX = 8'(CODE_SHOW_MAX);

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_kind, n_kind;
    logic [31:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic [31:0] r_left, n_left;
    logic [7:0]  r_shown, n_shown;
    logic [3:0]  r_patch, n_patch;
    logic [31:0] r_pc, n_pc;
    logic [31:0] r_spc, n_spc;
    logic [1:0]  r_err, n_err;

    orsp_pkg::t_result            w_res;
    logic                         w_res_vld;
    logic [31:0]                  w_num;
    logic [31:0]                  w_left_dec;
    logic [2:0]                   w_inc;
    logic [2:0]                   w_tag_next;
    logic [7:0]                   w_b;
    logic                         w_fire;
    logic                         w_opush, w_opop, w_ofull;

    orsp_pkg::t_result            r_omem [orsp_pkg::Q_DEPTH];
    logic [orsp_pkg::QA_W-1:0]    r_owr, r_ord;
    logic [orsp_pkg::QC_W-1:0]    r_ocnt, n_ocnt;

    assign w_b        = i_q_item.data;
    assign w_ofull    = (r_ocnt == orsp_pkg::QC_W'(orsp_pkg::Q_DEPTH));
    assign w_opop     = i_pop && !o_empty;
    assign w_fire     = i_q_valid && (!w_ofull || w_opop);
    assign o_q_pop    = w_fire;
    assign w_opush    = w_fire && w_res_vld;
    assign w_left_dec = (r_left != '0) ? r_left - 32'd1 : r_left;

    // next phase and pc step of a record tag
    always_comb begin
        w_inc      = 3'd0;
        w_tag_next = PH_NUM_FIRST;
        case (i_q_item.tag_kind)
            orsp_pkg::K_INIT: begin
                w_inc      = 3'd4;
                w_tag_next = PH_TAG;
            end
            orsp_pkg::K_BYTE: begin
                w_inc      = 3'd1;
                w_tag_next = PH_PATCH;
            end
            orsp_pkg::K_SHORT: begin
                w_inc      = 3'd2;
                w_tag_next = PH_PATCH;
            end
            orsp_pkg::K_WORD: begin
                w_inc      = 3'd4;
                w_tag_next = PH_PATCH;
            end
            orsp_pkg::K_GLOBAL, orsp_pkg::K_LABEL: w_tag_next = PH_STRING;
            default: w_tag_next = PH_NUM_FIRST;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_left    = r_left;
        n_shown   = r_shown;
        n_patch   = r_patch;
        n_pc      = r_pc;
        n_spc     = r_spc;
        n_err     = r_err;
        w_res     = '0;
        w_res_vld = 1'b0;
        w_num     = '0;

        if (r_phase == PH_DONE) begin
            w_res_vld           = 1'b1;
            w_res.event_res     = orsp_pkg::EV_DONE;
            w_res.record_pc     = r_pc;
        end else if (r_phase == PH_ERR) begin
            w_res_vld           = 1'b1;
            w_res.event_res     = orsp_pkg::EV_ERROR;
            w_res.error_code    = r_err;
            w_res.record_pc     = r_spc;
        end else if (i_q_item.is_end) begin
            w_res_vld = 1'b1;
            if (r_phase == PH_TAG) begin
                n_phase             = PH_DONE;
                w_res.event_res     = orsp_pkg::EV_DONE;
                w_res.record_pc     = r_pc;
            end else begin
                n_phase             = PH_ERR;
                n_err               = orsp_pkg::ERR_END;
                w_res.event_res     = orsp_pkg::EV_ERROR;
                w_res.error_code    = orsp_pkg::ERR_END;
                w_res.record_pc     = r_spc;
            end
        end else begin
            w_res.record_pc = r_spc;
            case (r_phase)
                PH_TAG: begin
                    w_res_vld = 1'b1;
                    if (!i_q_item.tag_ok) begin
                        n_phase          = PH_ERR;
                        n_err            = orsp_pkg::ERR_TAG;
                        w_res.event_res  = orsp_pkg::EV_ERROR;
                        w_res.error_code = orsp_pkg::ERR_TAG;
                    end else begin
                        n_kind            = i_q_item.tag_kind;
                        n_patch           = '0;
                        n_spc             = r_pc;
                        n_pc              = r_pc + {29'd0, w_inc};
                        n_phase           = w_tag_next;
                        w_res.event_res   = orsp_pkg::EV_START;
                        w_res.record_pc   = r_pc;
                        w_res.record_done = (i_q_item.tag_kind == orsp_pkg::K_INIT);
                    end
                end
                PH_NUM_FIRST, PH_NUM_CONT: begin
                    if (r_phase == PH_NUM_FIRST) begin
                        n_neg = w_b[6];
                        n_acc = {26'd0, w_b[5:0]};
                    end else begin
                        n_acc = {r_acc[24:0], w_b[6:0]};
                    end
                    if (w_b[7]) begin
                        n_phase = PH_NUM_CONT;
                    end else begin
                        // last byte of the number: act on the record kind
                        w_num             = n_neg ? 32'd0 - n_acc : n_acc;
                        w_res_vld         = 1'b1;
                        w_res.event_res   = orsp_pkg::EV_NUMBER;
                        w_res.value       = w_num;
                        case (r_kind)
                            orsp_pkg::K_CODE: begin
                                n_pc    = r_pc + w_num;
                                n_left  = w_num[31] ? '0 : w_num;
                                n_shown = '0;
                                if (w_num[31] || w_num == '0) begin
                                    w_res.record_done = 1'b1;
                                    n_phase           = PH_TAG;
                                end else begin
                                    n_phase = PH_CODE;
                                end
                            end
                            orsp_pkg::K_BSS: begin
                                n_pc              = r_pc + w_num;
                                w_res.record_done = 1'b1;
                                n_phase           = PH_TAG;
                            end
                            orsp_pkg::K_DATA, orsp_pkg::K_COMMON: n_phase = PH_STRING;
                            orsp_pkg::K_BYTE, orsp_pkg::K_SHORT, orsp_pkg::K_WORD: begin
                                w_res.patch_index = r_patch;
                                n_phase           = PH_PATCH;
                            end
                            default: begin
                                w_res.record_done = 1'b1;
                                n_phase           = PH_TAG;
                            end
                        endcase
                    end
                end
                PH_CODE: begin
                    n_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_phase = PH_TAG;
                    end
                    // show the first bytes, drop the rest silently
                    if (r_shown < SHOW_MAX) begin
                        n_shown           = r_shown + 8'd1;
                        w_res_vld         = 1'b1;
                        w_res.event_res   = orsp_pkg::EV_CODE;
                        w_res.value       = {24'd0, w_b};
                        w_res.record_done = (w_left_dec == '0);
                    end
                end
                PH_STRING: begin
                    w_res_vld = 1'b1;
                    if (w_b != 8'd0) begin
                        w_res.event_res = orsp_pkg::EV_CHAR;
                        w_res.value     = {24'd0, w_b};
                    end else begin
                        n_phase           = PH_TAG;
                        w_res.event_res   = orsp_pkg::EV_STREND;
                        w_res.record_done = 1'b1;
                    end
                end
                PH_PATCH: begin
                    w_res_vld = 1'b1;
                    if (i_q_item.is_ptag) begin
                        n_patch           = 4'(w_b - orsp_pkg::PATCH_BASE);
                        n_phase           = PH_NUM_FIRST;
                        w_res.event_res   = orsp_pkg::EV_PATCH;
                        w_res.patch_index = 4'(w_b - orsp_pkg::PATCH_BASE);
                    end else if (i_q_item.is_tgt) begin
                        n_phase           = PH_STRING;
                        w_res.event_res   = orsp_pkg::EV_TARGET;
                        w_res.target_kind = 2'(w_b - orsp_pkg::TARGET_BASE);
                    end else if (i_q_item.is_mtgt) begin
                        n_phase           = PH_TAG;
                        w_res.event_res   = orsp_pkg::EV_TARGET;
                        w_res.target_kind = orsp_pkg::TK_MODULE;
                        w_res.record_done = 1'b1;
                    end else begin
                        n_phase          = PH_ERR;
                        n_err            = orsp_pkg::ERR_TARGET;
                        w_res.event_res  = orsp_pkg::EV_ERROR;
                        w_res.error_code = orsp_pkg::ERR_TARGET;
                    end
                end
                default: begin
                    w_res_vld        = 1'b1;
                    n_phase          = PH_ERR;
                    n_err            = orsp_pkg::ERR_END;
                    w_res.event_res  = orsp_pkg::EV_ERROR;
                    w_res.error_code = orsp_pkg::ERR_END;
                end
            endcase
        end
        w_res.record_kind = n_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_kind  <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_left  <= '0;
            r_shown <= '0;
            r_patch <= '0;
            r_pc    <= '0;
            r_spc   <= '0;
            r_err   <= orsp_pkg::ERR_NONE;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_left  <= n_left;
            r_shown <= n_shown;
            r_patch <= n_patch;
            r_pc    <= n_pc;
            r_spc   <= n_spc;
            r_err   <= n_err;
        end
    end

    // result queue
    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_omem[r_ord];

    always_comb begin
        n_ocnt = r_ocnt;
        if (w_opush && !w_opop) begin
            n_ocnt = r_ocnt + 1'b1;
        end else if (w_opop && !w_opush) begin
            n_ocnt = r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            r_ocnt <= n_ocnt;
            if (w_opush) begin
                r_owr <= (r_owr == orsp_pkg::QA_W'(orsp_pkg::Q_DEPTH - 1)) ?
                         '0 : r_owr + 1'b1;
            end
            if (w_opop) begin
                r_ord <= (r_ord == orsp_pkg::QA_W'(orsp_pkg::Q_DEPTH - 1)) ?
                         '0 : r_ord + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_omem[r_owr] <= w_res;
        end
    end

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= orsp_pkg::QC_W'(orsp_pkg::Q_DEPTH))
        else $error("result queue overflow");

    a_halt_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_phase == PH_DONE || r_phase == PH_ERR)) |-> w_opush)
        else $error("halted parser dropped a result");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("parser left the done state");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERR) |=> (r_phase == PH_ERR && $stable(r_err)))
        else $error("error state or code changed");

endmodule
`default_nettype wire

// ----- design/object_record_stream_parser_top.sv -----
// Object record stream parser.
// Input channel: one stream byte per beat (i_data_byte, i_stream_end),
// taken at an edge where i_push is high and o_full is low.
// Result channel: one event per beat, the oldest on the o_* payload ports
// while o_empty is low, taken at an edge where i_pop is high.
// A byte gives at most one event: the leading bytes of a multi-byte
// number and the code bytes past CODE_SHOW_MAX give none.
// Path: a byte that gives an event is registered in the classify queue;
// the parser then writes its event into the result queue once that queue
// has room, and o_empty falls.
// Throughput: one byte per cycle while the result queue has room; the
// parser updates its whole state as it takes each byte.
// After the stream ends or an error is seen the parser holds, and every
// later byte repeats the same done or error event.
// Reset (synchronous, i_rst_n low) empties both queues and returns the
// parser to expect a record tag with a zero program counter.
// When the receiver stalls, the two-entry result queue fills, the parser
// holds, and o_full rises once the two-entry input queue is full.
`default_nettype none
module object_record_stream_parser_top #(
    parameter int CODE_SHOW_MAX = orsp_pkg::CODE_SHOW_MAX_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    output logic        o_full,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_stream_end,
    output logic        o_empty,
    input  wire         i_pop,
    output logic [3:0]  o_event_res,
    output logic [3:0]  o_record_kind,
    output logic signed [31:0] o_value,
    output logic [3:0]  o_patch_index,
    output logic [1:0]  o_target_kind,
    output logic [1:0]  o_error_code,
    output logic [31:0] o_record_pc,
    output logic        o_record_done
);

    logic               w_q_valid;
    logic               w_q_pop;
    orsp_pkg::t_item    w_q_item;
    orsp_pkg::t_result  w_res;

    orsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    orsp_back #(
        .CODE_SHOW_MAX (CODE_SHOW_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_res     (w_res)
    );

    assign o_event_res   = w_res.event_res;
    assign o_record_kind = w_res.record_kind;
    assign o_value       = signed'(w_res.value);
    assign o_patch_index = w_res.patch_index;
    assign o_target_kind = w_res.target_kind;
    assign o_error_code  = w_res.error_code;
    assign o_record_pc   = w_res.record_pc;
    assign o_record_done = w_res.record_done;

endmodule
`default_nettype wire

// ----- verif/object_record_stream_parser_top_tb.sv -----
`default_nettype none
module object_record_stream_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import orsp_pkg::*;

    localparam logic [7:0] TAG_CODE   = 8'h01;
    localparam logic [7:0] TAG_BSS    = 8'h02;
    localparam logic [7:0] TAG_INIT   = 8'h03;
    localparam logic [7:0] TAG_BYTE   = 8'h09;
    localparam logic [7:0] TAG_SHORT  = 8'h0a;
    localparam logic [7:0] TAG_WORD   = 8'h0c;
    localparam logic [7:0] TAG_MODULE = 8'h20;
    localparam logic [7:0] TAG_GLOBAL = 8'h22;
    localparam logic [7:0] TAG_LABEL  = 8'h23;
    localparam logic [7:0] TAG_DATA   = 8'h24;
    localparam logic [7:0] TAG_COMMON = 8'h25;

    localparam logic [7:0] TGT_LABEL       = 8'h0f;
    localparam logic [7:0] TGT_DATA_MODULE = 8'h11;
    localparam logic [7:0] TGT_MODULE      = 8'h12;
    localparam logic [7:0] PATCH_TAG_FIRST = 8'h13;
    localparam logic [7:0] PATCH_TAG_LAST  = 8'h1f;

    localparam int RANDOM_BYTES  = 700;
    localparam int PACE_SPAN     = 150;
    localparam int DIRECTED_LEN  = 33;
    localparam int DRAIN_LIMIT   = 5000;

    typedef enum logic [2:0] {
        PH_TAG, PH_NUM_FIRST, PH_NUM_MORE, PH_CODE,
        PH_STRING, PH_PATCH, PH_HALT_DONE, PH_HALT_ERR
    } parse_phase_e;

    typedef enum int {
        PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH
    } pace_e;

    typedef struct {
        logic [7:0] data;
        logic       stream_end;
        bit         typed;
        t_result    want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_stream_end = 1'b0;
    logic        i_pop = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [3:0]  o_event_res;
    logic [3:0]  o_record_kind;
    logic signed [31:0] o_value;
    logic [3:0]  o_patch_index;
    logic [1:0]  o_target_kind;
    logic [1:0]  o_error_code;
    logic [31:0] o_record_pc;
    logic        o_record_done;

    // parser state as predicted
    parse_phase_e prs_phase = PH_TAG;
    logic [3:0]  prs_kind = K_CODE;
    logic [31:0] prs_acc = 32'd0;
    logic        prs_neg = 1'b0;
    logic [31:0] prs_code_left = 32'd0;
    logic [7:0]  prs_shown = 8'd0;
    logic [3:0]  prs_patch = 4'd0;
    logic [31:0] prs_pc = 32'd0;
    logic [31:0] prs_start_pc = 32'd0;
    logic [1:0]  prs_err = ERR_NONE;

    t_result expected_events [$];
    int      error_count = 0;
    int      bytes_sent = 0;
    pace_e   pace = PACE_FULL;

    stim_row_t directed_rows [DIRECTED_LEN] = '{
        '{TAG_INIT,   1'b0, 1'b1, '{EV_START,  K_INIT, 32'd0,  4'd0, 2'd0, ERR_NONE, 32'd0, 1'b1}},
        '{TAG_BSS,    1'b0, 1'b1, '{EV_START,  K_BSS,  32'd0,  4'd0, 2'd0, ERR_NONE, 32'd4, 1'b0}},
        '{8'h3f,      1'b0, 1'b1, '{EV_NUMBER, K_BSS,  32'd63, 4'd0, 2'd0, ERR_NONE, 32'd4, 1'b1}},
        '{TAG_CODE,   1'b0, 1'b1, '{EV_START,  K_CODE, 32'd0,  4'd0, 2'd0, ERR_NONE, 32'd67, 1'b0}},
        // negative count: no code bytes, the number closes the record
        '{8'h41,      1'b0, 1'b1,
          '{EV_NUMBER, K_CODE, 32'hffff_ffff, 4'd0, 2'd0, ERR_NONE, 32'd67, 1'b1}},
        '{TAG_CODE,   1'b0, 1'b0, '0},
        '{8'h02,      1'b0, 1'b0, '0},
        '{8'h00,      1'b0, 1'b0, '0},
        '{8'hff,      1'b0, 1'b0, '0},
        '{TAG_MODULE, 1'b0, 1'b0, '0},
        '{8'hff,      1'b0, 1'b0, '0},
        '{8'h7f,      1'b0, 1'b0, '0},
        '{TAG_GLOBAL, 1'b0, 1'b0, '0},
        '{8'hff,      1'b0, 1'b0, '0},
        '{8'h00,      1'b0, 1'b0, '0},
        '{TAG_SHORT,  1'b0, 1'b0, '0},
        '{PATCH_TAG_LAST, 1'b0, 1'b0, '0},
        '{8'h01,      1'b0, 1'b0, '0},
        '{TGT_DATA_MODULE, 1'b0, 1'b0, '0},
        '{8'h00,      1'b0, 1'b0, '0},
        '{TAG_BYTE,   1'b0, 1'b0, '0},
        '{TGT_LABEL,  1'b0, 1'b0, '0},
        '{8'h00,      1'b0, 1'b0, '0},
        '{TAG_WORD,   1'b0, 1'b0, '0},
        '{TGT_MODULE, 1'b0, 1'b0, '0},
        '{TAG_LABEL,  1'b0, 1'b0, '0},
        '{8'h00,      1'b0, 1'b0, '0},
        '{TAG_DATA,   1'b0, 1'b0, '0},
        '{8'h00,      1'b0, 1'b0, '0},
        '{8'h00,      1'b0, 1'b0, '0},
        '{TAG_COMMON, 1'b0, 1'b0, '0},
        '{8'h01,      1'b0, 1'b0, '0},
        '{8'h00,      1'b0, 1'b0, '0}
    };

    object_record_stream_parser_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_data_byte   (i_data_byte),
        .i_stream_end  (i_stream_end),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_event_res   (o_event_res),
        .o_record_kind (o_record_kind),
        .o_value       (o_value),
        .o_patch_index (o_patch_index),
        .o_target_kind (o_target_kind),
        .o_error_code  (o_error_code),
        .o_record_pc   (o_record_pc),
        .o_record_done (o_record_done)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_result make_event(logic [3:0] ev, logic [31:0] val, logic [3:0] pidx,
                                           logic [1:0] tk, logic [1:0] ec, logic [31:0] pc,
                                           logic done);
        t_result r;
        r.event_res   = ev;
        r.record_kind = prs_kind;
        r.value       = val;
        r.patch_index = pidx;
        r.target_kind = tk;
        r.error_code  = ec;
        r.record_pc   = pc;
        r.record_done = done;
        return r;
    endfunction

    function automatic t_result parse_fault(logic [1:0] code);
        prs_phase = PH_HALT_ERR;
        prs_err   = code;
        return make_event(EV_ERROR, 32'd0, 4'd0, 2'd0, code, prs_start_pc, 1'b0);
    endfunction

    function automatic t_result finish_number();
        logic [31:0] n;
        logic [3:0]  pidx;
        logic        done;
        n    = prs_neg ? 32'd0 - prs_acc : prs_acc;
        pidx = 4'd0;
        done = 1'b0;
        case (prs_kind)
            K_CODE: begin
                prs_pc        = prs_pc + n;
                prs_code_left = (n != 32'd0 && !n[31]) ? n : 32'd0;
                prs_shown     = 8'd0;
                if (prs_code_left == 32'd0) begin
                    done      = 1'b1;
                    prs_phase = PH_TAG;
                end else begin
                    prs_phase = PH_CODE;
                end
            end
            K_BSS: begin
                prs_pc    = prs_pc + n;
                done      = 1'b1;
                prs_phase = PH_TAG;
            end
            K_DATA, K_COMMON: begin
                prs_phase = PH_STRING;
            end
            K_BYTE, K_SHORT, K_WORD: begin
                pidx      = prs_patch;
                prs_phase = PH_PATCH;
            end
            default: begin
                done      = 1'b1;
                prs_phase = PH_TAG;
            end
        endcase
        return make_event(EV_NUMBER, n, pidx, 2'd0, ERR_NONE, prs_start_pc, done);
    endfunction

    // advance the predicted parser by one byte; returns 1 when the byte gives an event
    function automatic bit parse_stream_byte(input logic [7:0] b, input logic e,
                                             output t_result ev);
        logic [3:0]   kind;
        parse_phase_e next_phase;
        logic [31:0]  inc;
        ev = '0;
        if (prs_phase == PH_HALT_DONE) begin
            ev = make_event(EV_DONE, 32'd0, 4'd0, 2'd0, ERR_NONE, prs_pc, 1'b0);
            return 1'b1;
        end
        if (prs_phase == PH_HALT_ERR) begin
            ev = make_event(EV_ERROR, 32'd0, 4'd0, 2'd0, prs_err, prs_start_pc, 1'b0);
            return 1'b1;
        end
        if (e) begin
            if (prs_phase == PH_TAG) begin
                prs_phase = PH_HALT_DONE;
                ev = make_event(EV_DONE, 32'd0, 4'd0, 2'd0, ERR_NONE, prs_pc, 1'b0);
            end else begin
                ev = parse_fault(ERR_END);
            end
            return 1'b1;
        end
        case (prs_phase)
            PH_TAG: begin
                inc        = 32'd0;
                next_phase = PH_NUM_FIRST;
                kind       = K_CODE;
                case (b)
                    TAG_CODE:   kind = K_CODE;
                    TAG_BSS:    kind = K_BSS;
                    TAG_INIT: begin
                        kind = K_INIT; next_phase = PH_TAG; inc = 32'd4;
                    end
                    TAG_BYTE: begin
                        kind = K_BYTE; next_phase = PH_PATCH; inc = 32'd1;
                    end
                    TAG_SHORT: begin
                        kind = K_SHORT; next_phase = PH_PATCH; inc = 32'd2;
                    end
                    TAG_WORD: begin
                        kind = K_WORD; next_phase = PH_PATCH; inc = 32'd4;
                    end
                    TAG_MODULE: kind = K_MODULE;
                    TAG_GLOBAL: begin
                        kind = K_GLOBAL; next_phase = PH_STRING;
                    end
                    TAG_LABEL: begin
                        kind = K_LABEL; next_phase = PH_STRING;
                    end
                    TAG_DATA:   kind = K_DATA;
                    TAG_COMMON: kind = K_COMMON;
                    default: begin
                        ev = parse_fault(ERR_TAG);
                        return 1'b1;
                    end
                endcase
                prs_kind     = kind;
                prs_patch    = 4'd0;
                prs_start_pc = prs_pc;
                prs_pc       = prs_pc + inc;
                prs_phase    = next_phase;
                ev = make_event(EV_START, 32'd0, 4'd0, 2'd0, ERR_NONE, prs_start_pc,
                                kind == K_INIT);
                return 1'b1;
            end
            PH_NUM_FIRST: begin
                prs_neg = b[6];
                prs_acc = {26'd0, b[5:0]};
                if (b[7]) begin
                    prs_phase = PH_NUM_MORE;
                    return 1'b0;
                end
                ev = finish_number();
                return 1'b1;
            end
            PH_NUM_MORE: begin
                prs_acc = (prs_acc << 7) + {25'd0, b[6:0]};
                if (b[7])
                    return 1'b0;
                ev = finish_number();
                return 1'b1;
            end
            PH_CODE: begin
                if (prs_code_left != 32'd0)
                    prs_code_left = prs_code_left - 32'd1;
                if (prs_code_left == 32'd0)
                    prs_phase = PH_TAG;
                // past the shown window the bytes are swallowed
                if (prs_shown < 8'(CODE_SHOW_MAX_DEF)) begin
                    prs_shown = prs_shown + 8'd1;
                    ev = make_event(EV_CODE, {24'd0, b}, 4'd0, 2'd0, ERR_NONE, prs_start_pc,
                                    prs_code_left == 32'd0);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_STRING: begin
                if (b != 8'd0) begin
                    ev = make_event(EV_CHAR, {24'd0, b}, 4'd0, 2'd0, ERR_NONE, prs_start_pc, 1'b0);
                end else begin
                    prs_phase = PH_TAG;
                    ev = make_event(EV_STREND, 32'd0, 4'd0, 2'd0, ERR_NONE, prs_start_pc, 1'b1);
                end
                return 1'b1;
            end
            PH_PATCH: begin
                if (b inside {[PATCH_TAG_FIRST:PATCH_TAG_LAST]}) begin
                    prs_patch = 4'(b - PATCH_BASE);
                    prs_phase = PH_NUM_FIRST;
                    ev = make_event(EV_PATCH, 32'd0, prs_patch, 2'd0, ERR_NONE, prs_start_pc, 1'b0);
                end else if (b inside {[TARGET_BASE:TGT_DATA_MODULE]}) begin
                    prs_phase = PH_STRING;
                    ev = make_event(EV_TARGET, 32'd0, 4'd0, 2'(b - TARGET_BASE), ERR_NONE,
                                    prs_start_pc, 1'b0);
                end else if (b == TGT_MODULE) begin
                    prs_phase = PH_TAG;
                    ev = make_event(EV_TARGET, 32'd0, 4'd0, TK_MODULE, ERR_NONE, prs_start_pc, 1'b1);
                end else begin
                    ev = parse_fault(ERR_TARGET);
                end
                return 1'b1;
            end
            default: begin
                ev = parse_fault(ERR_END);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic push_stream_byte(input logic [7:0] b, input logic e, input bit typed,
                                    input t_result want);
        int      idle_pct;
        t_result ev;
        pace     = pace_e'((bytes_sent / PACE_SPAN) % 4);
        idle_pct = (pace == PACE_SENDER_IDLE) ? 57 : (pace == PACE_BOTH) ? 13 : 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push       <= 1'b1;
        i_data_byte  <= b;
        i_stream_end <= e;
        do @(posedge i_clk); while (o_full);
        bytes_sent++;
        if (parse_stream_byte(b, e, ev))
            expected_events.push_back(typed ? want : ev);
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_stream_byte(b, 1'b0, 1'b0, '0);
    endtask

    task automatic push_random_number();
        int nbytes;
        nbytes = ($urandom_range(3) == 0) ? $urandom_range(6, 2) : 1;
        for (int k = nbytes - 1; k >= 0; k--)
            push_byte({k != 0, 7'($urandom_range(127))});
    endtask

    task automatic push_random_string();
        int len;
        len = $urandom_range(6);
        repeat (len) push_byte(8'($urandom_range(255, 1)));
        push_byte(8'd0);
    endtask

    task automatic push_code_record();
        int         count;
        int         mag;
        logic       neg;
        count = int'($urandom_range(48)) - 3;
        neg   = count < 0;
        mag   = neg ? -count : count;
        push_byte(TAG_CODE);
        // leading zero group keeps the count but takes the continuation path
        if ($urandom_range(2) == 0) begin
            push_byte({1'b1, neg, 6'd0});
            push_byte({1'b0, 7'(mag)});
        end else begin
            push_byte({1'b0, neg, 6'(mag)});
        end
        if (count > 0)
            repeat (count) push_byte(8'($urandom_range(255)));
    endtask

    task automatic push_patch_record(input logic [7:0] tag);
        int npatch;
        int tgt;
        push_byte(tag);
        npatch = $urandom_range(3);
        repeat (npatch) begin
            push_byte(PATCH_TAG_FIRST + 8'($urandom_range(12)));
            push_random_number();
        end
        tgt = $urandom_range(3);
        if (tgt == 3) begin
            push_byte(TGT_MODULE);
        end else begin
            push_byte(TARGET_BASE + 8'(tgt));
            push_random_string();
        end
    endtask

    task automatic push_random_record();
        case ($urandom_range(10))
            0: push_code_record();
            1: begin
                push_byte(TAG_BSS);
                push_random_number();
            end
            2: push_byte(TAG_INIT);
            3: push_patch_record(TAG_BYTE);
            4: push_patch_record(TAG_SHORT);
            5: push_patch_record(TAG_WORD);
            6: begin
                push_byte(TAG_MODULE);
                push_random_number();
            end
            7: begin
                push_byte(TAG_GLOBAL);
                push_random_string();
            end
            8: begin
                push_byte(TAG_LABEL);
                push_random_string();
            end
            9: begin
                push_byte(TAG_DATA);
                push_random_number();
                push_random_string();
            end
            default: begin
                push_byte(TAG_COMMON);
                push_random_number();
                push_random_string();
            end
        endcase
    endtask

    // close the stream one of four ways; the parser halts for good after this
    task automatic push_stream_close();
        logic [7:0] b;
        case ($urandom_range(3))
            0: push_stream_byte(8'($urandom_range(255)), 1'b1, 1'b0, '0);
            1: begin
                push_byte(TAG_GLOBAL);
                push_byte(8'($urandom_range(255, 1)));
                push_stream_byte(8'($urandom_range(255)), 1'b1, 1'b0, '0);
            end
            2: begin
                do b = 8'($urandom_range(255));
                while (b inside {TAG_CODE, TAG_BSS, TAG_INIT, TAG_BYTE, TAG_SHORT, TAG_WORD,
                                 TAG_MODULE, TAG_GLOBAL, TAG_LABEL, TAG_DATA, TAG_COMMON});
                push_byte(b);
            end
            default: begin
                push_byte(TAG_WORD);
                do b = 8'($urandom_range(255));
                while (b inside {[TARGET_BASE:PATCH_TAG_LAST]});
                push_byte(b);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_event();
        t_result want;
        if (expected_events.size() == 0) begin
            $display("%0t: unexpected event %0h expected none got kind %0h value %0h",
                     $time, o_event_res, o_record_kind, o_value);
            error_count++;
            return;
        end
        want = expected_events.pop_front();
        check_field("event_res",   32'(want.event_res),   32'(o_event_res));
        check_field("record_kind", 32'(want.record_kind), 32'(o_record_kind));
        check_field("value",       want.value,            o_value);
        check_field("patch_index", 32'(want.patch_index), 32'(o_patch_index));
        check_field("target_kind", 32'(want.target_kind), 32'(o_target_kind));
        check_field("error_code",  32'(want.error_code),  32'(o_error_code));
        check_field("record_pc",   want.record_pc,        o_record_pc);
        check_field("record_done", 32'(want.record_done), 32'(o_record_done));
    endtask

    always @(posedge i_clk) begin
        int stall_pct;
        stall_pct = (pace == PACE_RECEIVER_STALL) ? 57 : (pace == PACE_BOTH) ? 13 : 0;
        if (i_rst_n && i_pop && !o_empty)
            check_event();
        i_pop <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    initial begin
        int guard;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_LEN; r++)
            push_stream_byte(directed_rows[r].data, directed_rows[r].stream_end,
                             directed_rows[r].typed, directed_rows[r].want);

        while (bytes_sent < DIRECTED_LEN + RANDOM_BYTES)
            push_random_record();

        push_stream_close();
        // every byte after the halt must repeat the final event
        repeat (20) push_stream_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
        i_push <= 1'b0;

        guard = 0;
        while (expected_events.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_events.size() != 0) begin
            $display("%0t: %0d expected events never arrived", $time, expected_events.size());
            error_count++;
        end
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
